// ----- sv/host_health_reboot_supervisor_assert.svh -----
// Assertion macros for the reboot supervisor.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef HOST_HEALTH_REBOOT_SUPERVISOR_ASSERT_SVH
`define HOST_HEALTH_REBOOT_SUPERVISOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define HHRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HHRS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define HHRS_ASSERT(lbl, prop, msg)
`define HHRS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/hhrs_pkg.sv -----
package hhrs_pkg;

	typedef logic [1:0]  mode_t;
	typedef logic [1:0]  policy_t;
	typedef logic [7:0]  cnt_t;
	typedef logic [31:0] timer_t;
	typedef logic [2:0]  reg_idx_t;

	// Operating modes
	localparam mode_t MODE_LINK  = 2'd0;
	localparam mode_t MODE_MON   = 2'd1;
	localparam mode_t MODE_PULSE = 2'd2;
	localparam mode_t MODE_COOL  = 2'd3;

	// Update policy codes
	localparam policy_t POL_NO_LOGINS = 2'd0;
	localparam policy_t POL_LOGINS    = 2'd1;
	localparam policy_t POL_NONE      = 2'd2;

	// Service probe codes
	localparam logic [1:0] SVC_UP      = 2'd0;
	localparam logic [1:0] SVC_TIMEOUT = 2'd1;

	// Configuration register indexes
	localparam reg_idx_t REG_PING_LIMIT   = 3'd0;
	localparam reg_idx_t REG_WEDGE_LIMIT  = 3'd1;
	localparam reg_idx_t REG_UPDATE_LIMIT = 3'd2;
	localparam reg_idx_t REG_BUDGET       = 3'd3;
	localparam reg_idx_t REG_WINDOW       = 3'd4;
	localparam reg_idx_t REG_PULSE        = 3'd5;
	localparam reg_idx_t REG_COOLDOWN     = 3'd6;
	localparam reg_idx_t REG_RETRY_GAP    = 3'd7;

	// Register reset values
	localparam cnt_t   RST_PING_LIMIT   = 8'd10;
	localparam cnt_t   RST_WEDGE_LIMIT  = 8'd5;
	localparam cnt_t   RST_UPDATE_LIMIT = 8'd30;
	localparam cnt_t   RST_BUDGET       = 8'd3;
	localparam timer_t RST_WINDOW       = 32'd3600000;
	localparam timer_t RST_PULSE        = 32'd10000;
	localparam timer_t RST_COOLDOWN     = 32'd120000;
	localparam timer_t RST_RETRY_GAP    = 32'd30000;

	typedef struct packed {
		logic              kind;
		logic              link_up;
		logic              ping_ok;
		logic [1:0]        service_result;
		logic              health_ok;
		logic              login_ok;
		logic signed [7:0] login_count;
	} in_item_t;

	function automatic cnt_t sat_inc8(input cnt_t v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic timer_t sat_inc32(input timer_t v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

// ----- sv/hhrs_if.sv -----
interface hhrs_in_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic              link_up;
	logic              ping_ok;
	logic [1:0]        service_result;
	logic              health_ok;
	logic              login_ok;
	logic signed [7:0] login_count;

	modport source (output valid, kind, link_up, ping_ok, service_result, health_ok,
		login_ok, login_count, input ready);
	modport sink (input valid, kind, link_up, ping_ok, service_result, health_ok,
		login_ok, login_count, output ready);
endinterface

interface hhrs_out_if;
	logic                 valid;
	logic                 ready;
	logic                 relay_cut;
	hhrs_pkg::mode_t      mode;
	logic                 reboot_started;
	logic                 budget_blocked;
	hhrs_pkg::cnt_t       ping_misses;
	hhrs_pkg::cnt_t       wedge_misses;
	hhrs_pkg::cnt_t       update_misses;
	hhrs_pkg::cnt_t       reboots_used;

	modport source (output valid, relay_cut, mode, reboot_started, budget_blocked,
		ping_misses, wedge_misses, update_misses, reboots_used, input ready);
	modport sink (input valid, relay_cut, mode, reboot_started, budget_blocked,
		ping_misses, wedge_misses, update_misses, reboots_used, output ready);
endinterface

interface hhrs_cfg_if;
	logic               valid;
	logic               ready;
	hhrs_pkg::reg_idx_t index;
	logic [31:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/host_health_reboot_supervisor.sv -----
// Host health reboot supervisor: power-cycles a host through a relay.
// item_in carries one item per handshake: a 1 ms tick (kind 0) or a probe
// report (kind 1). result_out returns exactly one result item per input item,
// in order: relay state, mode, reboot/blocked flags and the counter values.
// cfg is a write-only register port (index, data); its ready is always high.
// Write it only while the block is idle.
// Path: an accepted item is registered in the input register, processed by one
// combinational pass, and registered in the result register for result_out.
// Throughput: one item per cycle while result_out.ready is high; the only loop is
// the state update between items, closing in that single combinational pass.
// Stall: when result_out.ready is low the result register holds; the input
// register still takes one more item, then item_in.ready drops until the
// result is taken.
// Reset (arst_n low): mode goes to link wait, all counters, timers and the
// update policy clear, registers return to their defaults, no item is held.
`include "host_health_reboot_supervisor_assert.svh"

module host_health_reboot_supervisor (
	input  logic             clk,
	input  logic             arst_n,
	hhrs_in_if.sink          item_in,
	hhrs_out_if.source       result_out,
	hhrs_cfg_if.sink         cfg
);

	// Configuration registers
	hhrs_pkg::cnt_t   ping_limit_q;
	hhrs_pkg::cnt_t   wedge_limit_q;
	hhrs_pkg::cnt_t   update_limit_q;
	hhrs_pkg::cnt_t   budget_q;
	hhrs_pkg::timer_t window_q;
	hhrs_pkg::timer_t pulse_q;
	hhrs_pkg::timer_t cooldown_q;
	hhrs_pkg::timer_t retry_gap_q;

	// Supervisor state
	hhrs_pkg::mode_t   mode_q, mode_n;
	hhrs_pkg::cnt_t    ping_q, ping_n;
	hhrs_pkg::cnt_t    wedge_q, wedge_n;
	hhrs_pkg::cnt_t    upd_q, upd_n;
	hhrs_pkg::policy_t policy_q, policy_n;
	hhrs_pkg::cnt_t    reboots_q, reboots_n;
	hhrs_pkg::timer_t  win_q, win_n;
	hhrs_pkg::timer_t  modet_q, modet_n;
	hhrs_pkg::timer_t  retry_q, retry_n;
	logic              started_n;
	logic              blocked_n;
	logic              req;
	hhrs_pkg::policy_t pol_new;

	// Input stage
	logic                 valid_s1;
	hhrs_pkg::in_item_t   in_s1;

	// Result stage
	logic                 valid_s2;
	hhrs_pkg::mode_t      res_mode_s2;
	logic                 res_started_s2;
	logic                 res_blocked_s2;
	hhrs_pkg::cnt_t       res_ping_s2;
	hhrs_pkg::cnt_t       res_wedge_s2;
	hhrs_pkg::cnt_t       res_upd_s2;
	hhrs_pkg::cnt_t       res_reboots_s2;

	logic adv;
	logic in_fire;

	// Advance when an item waits in the input stage and the result slot is free
	// or being emptied this cycle.
	assign adv          = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || adv;
	assign in_fire      = item_in.valid && item_in.ready;
	assign cfg.ready    = 1'b1;

	// ---------------------------------------------------------------
	// Configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_limit_q   <= hhrs_pkg::RST_PING_LIMIT;
			wedge_limit_q  <= hhrs_pkg::RST_WEDGE_LIMIT;
			update_limit_q <= hhrs_pkg::RST_UPDATE_LIMIT;
			budget_q       <= hhrs_pkg::RST_BUDGET;
			window_q       <= hhrs_pkg::RST_WINDOW;
			pulse_q        <= hhrs_pkg::RST_PULSE;
			cooldown_q     <= hhrs_pkg::RST_COOLDOWN;
			retry_gap_q    <= hhrs_pkg::RST_RETRY_GAP;
		end else if (cfg.valid) begin
			case (cfg.index)
				hhrs_pkg::REG_PING_LIMIT:   ping_limit_q   <= cfg.data[7:0];
				hhrs_pkg::REG_WEDGE_LIMIT:  wedge_limit_q  <= cfg.data[7:0];
				hhrs_pkg::REG_UPDATE_LIMIT: update_limit_q <= cfg.data[7:0];
				hhrs_pkg::REG_BUDGET:       budget_q       <= cfg.data[7:0];
				hhrs_pkg::REG_WINDOW:       window_q       <= cfg.data;
				hhrs_pkg::REG_PULSE:        pulse_q        <= cfg.data;
				hhrs_pkg::REG_COOLDOWN:     cooldown_q     <= cfg.data;
				hhrs_pkg::REG_RETRY_GAP:    retry_gap_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_s1.kind           <= item_in.kind;
			in_s1.link_up        <= item_in.link_up;
			in_s1.ping_ok        <= item_in.ping_ok;
			in_s1.service_result <= item_in.service_result;
			in_s1.health_ok      <= item_in.health_ok;
			in_s1.login_ok       <= item_in.login_ok;
			in_s1.login_count    <= item_in.login_count;
		end
	end

	// ---------------------------------------------------------------
	// Next state for the item held in the input stage
	// ---------------------------------------------------------------
	assign pol_new = (in_s1.login_count == 8'sd0) ? hhrs_pkg::POL_NO_LOGINS
		: hhrs_pkg::POL_LOGINS;

	always_comb begin
		mode_n    = mode_q;
		ping_n    = ping_q;
		wedge_n   = wedge_q;
		upd_n     = upd_q;
		policy_n  = policy_q;
		reboots_n = reboots_q;
		win_n     = win_q;
		modet_n   = modet_q;
		retry_n   = retry_q;
		started_n = 1'b0;
		blocked_n = 1'b0;
		req       = 1'b0;

		// A tick advances all three timers; they stop at all ones.
		if (!in_s1.kind) begin
			win_n   = hhrs_pkg::sat_inc32(win_q);
			modet_n = hhrs_pkg::sat_inc32(modet_q);
			retry_n = hhrs_pkg::sat_inc32(retry_q);
		end

		case (mode_q)
			hhrs_pkg::MODE_LINK: begin
				if (in_s1.link_up) begin
					mode_n   = hhrs_pkg::MODE_MON;
					modet_n  = '0;
					ping_n   = '0;
					wedge_n  = '0;
					upd_n    = '0;
					policy_n = hhrs_pkg::POL_NONE;
				end
			end
			hhrs_pkg::MODE_MON: begin
				if (!in_s1.link_up) begin
					// Link lost: drop all evidence, fall back to link wait once the
					// retry gap has passed.
					ping_n   = '0;
					wedge_n  = '0;
					upd_n    = '0;
					policy_n = hhrs_pkg::POL_NONE;
					if (retry_n >= retry_gap_q) begin
						retry_n = '0;
						mode_n  = hhrs_pkg::MODE_LINK;
						modet_n = '0;
					end
				end else if (in_s1.kind) begin
					if (!in_s1.ping_ok) begin
						wedge_n  = '0;
						upd_n    = '0;
						policy_n = hhrs_pkg::POL_NONE;
						ping_n   = hhrs_pkg::sat_inc8(ping_q);
						req      = (ping_n >= ping_limit_q);
					end else begin
						ping_n = '0;
						if (in_s1.service_result == hhrs_pkg::SVC_UP) begin
							wedge_n  = '0;
							upd_n    = '0;
							policy_n = hhrs_pkg::POL_NONE;
						end else if (in_s1.service_result != hhrs_pkg::SVC_TIMEOUT &&
							in_s1.health_ok && in_s1.login_ok) begin
							// Service down on a healthy host: likely an update in progress, counted
							// against the update limit, or the wedge limit when the login count is zero.
							wedge_n = '0;
							if (pol_new != policy_q) begin
								upd_n    = hhrs_pkg::sat_inc8('0);
								policy_n = pol_new;
							end else begin
								upd_n = hhrs_pkg::sat_inc8(upd_q);
							end
							if (pol_new == hhrs_pkg::POL_NO_LOGINS) begin
								req = (upd_n >= wedge_limit_q);
							end else begin
								req = (upd_n >= update_limit_q);
							end
						end else begin
							// Timeout, or down with an unhealthy host: wedge miss.
							upd_n    = '0;
							policy_n = hhrs_pkg::POL_NONE;
							wedge_n  = hhrs_pkg::sat_inc8(wedge_q);
							req      = (wedge_n >= wedge_limit_q);
						end
					end
				end
			end
			hhrs_pkg::MODE_PULSE: begin
				if (modet_n >= pulse_q) begin
					mode_n  = hhrs_pkg::MODE_COOL;
					modet_n = '0;
				end
			end
			default: begin
				if (modet_n >= cooldown_q) begin
					mode_n   = hhrs_pkg::MODE_MON;
					modet_n  = '0;
					ping_n   = '0;
					wedge_n  = '0;
					upd_n    = '0;
					policy_n = hhrs_pkg::POL_NONE;
				end
			end
		endcase

		// Reboot request: restart an expired window, clear the evidence, then
		// either spend one unit of budget or report the block.
		if (req) begin
			if (win_n >= window_q) begin
				win_n     = '0;
				reboots_n = '0;
			end
			ping_n   = '0;
			wedge_n  = '0;
			upd_n    = '0;
			policy_n = hhrs_pkg::POL_NONE;
			if (reboots_n >= budget_q) begin
				blocked_n = 1'b1;
			end else begin
				reboots_n = reboots_n + 8'd1;
				mode_n    = hhrs_pkg::MODE_PULSE;
				modet_n   = '0;
				started_n = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// State update
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= hhrs_pkg::MODE_LINK;
			ping_q    <= '0;
			wedge_q   <= '0;
			upd_q     <= '0;
			policy_q  <= hhrs_pkg::POL_NONE;
			reboots_q <= '0;
			win_q     <= '0;
			modet_q   <= '0;
			retry_q   <= '0;
		end else if (adv) begin
			mode_q    <= mode_n;
			ping_q    <= ping_n;
			wedge_q   <= wedge_n;
			upd_q     <= upd_n;
			policy_q  <= policy_n;
			reboots_q <= reboots_n;
			win_q     <= win_n;
			modet_q   <= modet_n;
			retry_q   <= retry_n;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_mode_s2    <= mode_n;
			res_started_s2 <= started_n;
			res_blocked_s2 <= blocked_n;
			res_ping_s2    <= ping_n;
			res_wedge_s2   <= wedge_n;
			res_upd_s2     <= upd_n;
			res_reboots_s2 <= reboots_n;
		end
	end

	assign result_out.valid          = valid_s2;
	assign result_out.relay_cut      = (res_mode_s2 == hhrs_pkg::MODE_PULSE);
	assign result_out.mode           = res_mode_s2;
	assign result_out.reboot_started = res_started_s2;
	assign result_out.budget_blocked = res_blocked_s2;
	assign result_out.ping_misses    = res_ping_s2;
	assign result_out.wedge_misses   = res_wedge_s2;
	assign result_out.update_misses  = res_upd_s2;
	assign result_out.reboots_used   = res_reboots_s2;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`HHRS_ASSERT_NEVER(a_start_and_block, valid_s2 && res_started_s2 && res_blocked_s2,
		"reboot started and blocked on the same item")
	`HHRS_ASSERT(a_start_state, valid_s2 && res_started_s2 |-> res_mode_s2 == hhrs_pkg::MODE_PULSE && res_ping_s2 == 8'd0 && res_wedge_s2 == 8'd0 && res_upd_s2 == 8'd0 && res_reboots_s2 != 8'd0,
		"reboot start without pulse mode or cleared counters")
	`HHRS_ASSERT(a_block_state, valid_s2 && res_blocked_s2 |-> res_mode_s2 == hhrs_pkg::MODE_MON && res_ping_s2 == 8'd0 && res_wedge_s2 == 8'd0 && res_upd_s2 == 8'd0,
		"blocked reboot left counters set or left monitor")
	`HHRS_ASSERT(a_pulse_exit, mode_q != $past(mode_q) && $past(mode_q) == hhrs_pkg::MODE_PULSE |-> mode_q == hhrs_pkg::MODE_COOL,
		"pulse mode left for a mode other than cooldown")
	`HHRS_ASSERT(a_policy_grace, policy_q == hhrs_pkg::POL_NONE |-> upd_q == 8'd0,
		"update misses counted with no policy chosen")

endmodule
